// ----- rtl/core/spc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared constants, register indexes and helpers for the per-channel speed PID.
// ----------------------------------------------------------------------------
package spc_pkg;

   localparam int CHANNELS = 2;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int GAIN_W  = 32;
   localparam int SPEED_W = 16;
   localparam int ERR_W   = SPEED_W + 1;
   localparam int DERR_W  = ERR_W + 1;
   localparam int SUM_W   = GAIN_W + 2;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P = 2'd0,
      REG_GAIN_I = 2'd1,
      REG_GAIN_D = 2'd2
   } csr_reg_type;

   localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = 32'sd4949279;
   localparam logic signed [GAIN_W-1:0] GAIN_I_RESET = 32'sd16777;
   localparam logic signed [GAIN_W-1:0] GAIN_D_RESET = 32'sd0;

   // Q8.24 limits: +/-10, +/-0.2, +/-100
   localparam logic signed [SUM_W-1:0] INTEG_LIMIT = 34'sd167772160;
   localparam logic signed [SUM_W-1:0] DERIV_LIMIT = 34'sd3355443;
   localparam logic signed [SUM_W-1:0] DRIVE_LIMIT = 34'sd1677721600;

   function automatic logic signed [SUM_W-1:0] clamp_sym(
      input logic signed [SUM_W-1:0] v,
      input logic signed [SUM_W-1:0] lim
   );
      logic signed [SUM_W-1:0] r;
      r = v;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/spc_sat_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_sat_mul
// Signed Q8.24 gain times signed integer, saturated to the 32-bit range.
// ----------------------------------------------------------------------------
module spc_sat_mul (
   input  logic signed [spc_pkg::GAIN_W-1:0] gain,
   input  logic signed [spc_pkg::DERR_W-1:0] x,
   output logic signed [spc_pkg::GAIN_W-1:0] prod
);

   localparam int PROD_W = spc_pkg::GAIN_W + spc_pkg::DERR_W;

   logic signed [PROD_W-1:0] full;
   logic                     ovf;

   assign full = PROD_W'(gain) * PROD_W'(x);
   // overflow when the bits above the 32-bit sign are not all copies of it
   assign ovf  = (full[PROD_W-1:spc_pkg::GAIN_W-1] != {(PROD_W-spc_pkg::GAIN_W+1){1'b0}}) &&
                 (full[PROD_W-1:spc_pkg::GAIN_W-1] != {(PROD_W-spc_pkg::GAIN_W+1){1'b1}});

   always_comb begin
      if (!ovf) begin
         prod = full[spc_pkg::GAIN_W-1:0];
      end else if (full[PROD_W-1]) begin
         prod = {1'b1, {(spc_pkg::GAIN_W-1){1'b0}}};
      end else begin
         prod = {1'b0, {(spc_pkg::GAIN_W-1){1'b1}}};
      end
   end

endmodule

// ----- rtl/core/speed_pid_per_channel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speed_pid_per_channel
// PID speed loop with integral, derivative and drive clamps, one loop per channel.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_stall is low and returns one drive
// value per item, in order. Each item passes through these registers in turn:
// input register, product register (the three gain multipliers), term
// register (integral update and derivative clamp), result register (P + I - D
// and the drive clamp). Per-channel integral and last error live in flops,
// are cleared by reset and are updated in pipeline stages that items pass
// one at a time, so back-to-back items on one channel see each other's state.
// req_stall follows rsp_stall only when every stage is full. Gains may be
// written while the block is idle and take effect for the next item.
// ----------------------------------------------------------------------------
module speed_pid_per_channel (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_channel,
   input  logic signed [spc_pkg::SPEED_W-1:0]     req_target_speed,
   input  logic signed [spc_pkg::SPEED_W-1:0]     req_measured_speed,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [spc_pkg::GAIN_W-1:0]      rsp_drive,
   input  logic                                   csr_we,
   input  logic [spc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [spc_pkg::GAIN_W-1:0]             csr_wdata
);

   localparam int GW = spc_pkg::GAIN_W;
   localparam int SW = spc_pkg::SUM_W;
   localparam int CW = spc_pkg::CH_IDX_W;

   logic signed [GW-1:0] gain_p_ff, gain_i_ff, gain_d_ff;

   logic signed [GW-1:0]             integ_ff [spc_pkg::CHANNELS];
   logic signed [spc_pkg::ERR_W-1:0] prev_err_ff [spc_pkg::CHANNELS];

   logic                 s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic [CW-1:0]        s1_ch_ff, s2_ch_ff;
   logic signed [spc_pkg::SPEED_W-1:0] s1_tgt_ff, s1_meas_ff;
   logic signed [GW-1:0] s2_p_ff, s2_i_ff, s2_d_ff;
   logic signed [GW-1:0] s3_p_ff, s3_i_ff, s3_d_ff;
   logic signed [GW-1:0] drive_ff;

   logic out_free, s3_free, s2_free, s1_free;
   logic req_take, s1_move, s2_move, s3_move;

   logic [CW-1:0]                     req_ch;
   logic signed [spc_pkg::ERR_W-1:0]  s1_err;
   logic signed [spc_pkg::DERR_W-1:0] s1_err_x, s1_derr;
   logic signed [GW-1:0]              p_prod, i_prod, d_prod;
   logic signed [SW-1:0]              integ_in, deriv_in, drive_sum, drive_in;

   // handshake chain
   assign out_free  = !out_v_ff || !rsp_stall;
   assign s3_free   = !s3_v_ff || out_free;
   assign s2_free   = !s2_v_ff || s3_free;
   assign s1_free   = !s1_v_ff || s2_free;
   assign req_stall = !s1_free;
   assign req_take  = req_valid && s1_free;
   assign s1_move   = s1_v_ff && s2_free;
   assign s2_move   = s2_v_ff && s3_free;
   assign s3_move   = s3_v_ff && out_free;

   assign req_ch = CW'(32'(req_channel) % spc_pkg::CHANNELS);

   // stage 1: error, error change, products
   assign s1_err   = spc_pkg::ERR_W'(s1_tgt_ff) - spc_pkg::ERR_W'(s1_meas_ff);
   assign s1_err_x = spc_pkg::DERR_W'(s1_err);
   assign s1_derr  = s1_err_x - spc_pkg::DERR_W'(prev_err_ff[s1_ch_ff]);

   spc_sat_mul u_mul_p (.gain(gain_p_ff), .x(s1_err_x), .prod(p_prod));
   spc_sat_mul u_mul_i (.gain(gain_i_ff), .x(s1_err_x), .prod(i_prod));
   spc_sat_mul u_mul_d (.gain(gain_d_ff), .x(s1_derr),  .prod(d_prod));

   // stage 2: integral update, derivative clamp
   assign integ_in = spc_pkg::clamp_sym(SW'(integ_ff[s2_ch_ff]) + SW'(s2_i_ff),
                                        spc_pkg::INTEG_LIMIT);
   assign deriv_in = spc_pkg::clamp_sym(SW'(s2_d_ff), spc_pkg::DERIV_LIMIT);

   // stage 3: drive
   assign drive_sum = SW'(s3_p_ff) + SW'(s3_i_ff) - SW'(s3_d_ff);
   assign drive_in  = spc_pkg::clamp_sym(drive_sum, spc_pkg::DRIVE_LIMIT);

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
         gain_p_ff <= spc_pkg::GAIN_P_RESET;
         gain_i_ff <= spc_pkg::GAIN_I_RESET;
         gain_d_ff <= spc_pkg::GAIN_D_RESET;
         for (int k = 0; k < spc_pkg::CHANNELS; k++) begin
            integ_ff[k]    <= '0;
            prev_err_ff[k] <= '0;
         end
      end else begin
         if (s1_free) begin
            s1_v_ff <= req_valid;
         end
         if (s2_free) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_free) begin
            s3_v_ff <= s2_v_ff;
         end
         if (out_free) begin
            out_v_ff <= s3_v_ff;
         end
         if (s1_move) begin
            prev_err_ff[s1_ch_ff] <= s1_err;
         end
         if (s2_move) begin
            integ_ff[s2_ch_ff] <= integ_in[GW-1:0];
         end
         if (csr_we) begin
            case (csr_index)
               spc_pkg::REG_GAIN_P: gain_p_ff <= csr_wdata;
               spc_pkg::REG_GAIN_I: gain_i_ff <= csr_wdata;
               spc_pkg::REG_GAIN_D: gain_d_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ch_ff   <= req_ch;
         s1_tgt_ff  <= req_target_speed;
         s1_meas_ff <= req_measured_speed;
      end
      if (s1_move) begin
         s2_ch_ff <= s1_ch_ff;
         s2_p_ff  <= p_prod;
         s2_i_ff  <= i_prod;
         s2_d_ff  <= d_prod;
      end
      if (s2_move) begin
         s3_p_ff <= s2_p_ff;
         s3_i_ff <= integ_in[GW-1:0];
         s3_d_ff <= deriv_in[GW-1:0];
      end
      if (s3_move) begin
         drive_ff <= drive_in[GW-1:0];
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_drive = drive_ff;

endmodule

// ----- bench/speed_pid_per_channel_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speed_pid_per_channel_test
// Self-checking bench for the per-channel speed PID. A short directed table
// (reset state, speed and gain extremes, ignored register index, zero gains)
// is followed by random segments, each with fresh gains and its own idle
// pattern. Drive values are checked in order: fixed table values where set,
// else a local predictor keeping its own integral and last error per channel.
// ----------------------------------------------------------------------------
module speed_pid_per_channel_test;

   localparam int     PIPE_DEPTH = 3;
   localparam int     SETTLE     = PIPE_DEPTH + 2;
   localparam int     SEGMENTS   = 10;
   localparam int     SEG_ITEMS  = 100;
   localparam longint INTEG_CAP  = 64'sd167772160;
   localparam longint DERIV_CAP  = 64'sd3355443;
   localparam longint DRIVE_CAP  = 64'sd1677721600;
   localparam logic [spc_pkg::CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type                       kind;
      logic                               ch;
      logic signed [15:0]                 tgt;
      logic signed [15:0]                 meas;
      logic                               fixed;
      logic signed [31:0]                 drive;
      logic [spc_pkg::CSR_IDX_W-1:0]      idx;
      logic [31:0]                        data;
   } step_type;

   localparam int PLAN_LEN = 28;
   localparam step_type PLAN [PLAN_LEN] = '{
      '{ROW_ITEM, 1'b0, 16'sd0, 16'sd0, 1'b1, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_ITEM, 1'b1, 16'sd0, 16'sd0, 1'b1, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_ITEM, 1'b0, 16'sh7FFF, 16'sh8000, 1'b1, 32'sd1677721600, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_ITEM, 1'b1, 16'sh8000, 16'sh7FFF, 1'b1, -32'sd1677721600, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_ITEM, 1'b0, 16'sd100, 16'sd90, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_ITEM, 1'b1, -16'sd5, 16'sd5, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_ITEM, 1'b0, 16'sd10, 16'sd10, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_D, 32'h7FFF_FFFF},
      '{ROW_ITEM, 1'b0, 16'sd1000, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_ITEM, 1'b0, 16'sd0, 16'sd1000, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_ITEM, 1'b1, 16'sh7FFF, 16'sh8000, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h8000_0000},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_I, 32'h8000_0000},
      '{ROW_ITEM, 1'b1, 16'sh8000, 16'sh7FFF, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_ITEM, 1'b0, 16'sh7FFF, 16'sh8000, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_I, 32'h7FFF_FFFF},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_D, 32'h8000_0000},
      '{ROW_ITEM, 1'b1, -16'sd1, 16'sd1, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, REG_SPARE, 32'h1234_5678},
      '{ROW_ITEM, 1'b0, -16'sd1, 16'sh8000, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_I, 32'h0},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_D, 32'h0},
      '{ROW_ITEM, 1'b1, 16'sd1234, -16'sd4321, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, spc_pkg::GAIN_P_RESET},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_I, spc_pkg::GAIN_I_RESET},
      '{ROW_CSR, 1'b0, 16'sd0, 16'sd0, 1'b0, 32'sd0, spc_pkg::REG_GAIN_D, spc_pkg::GAIN_D_RESET},
      '{ROW_ITEM, 1'b0, 16'sd7, 16'sd3, 1'b0, 32'sd0, spc_pkg::REG_GAIN_P, 32'h0}
   };

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_channel = 1'b0;
   logic signed [spc_pkg::SPEED_W-1:0]  req_target_speed = '0;
   logic signed [spc_pkg::SPEED_W-1:0]  req_measured_speed = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [spc_pkg::GAIN_W-1:0]   rsp_drive;
   logic                                csr_we = 1'b0;
   logic [spc_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [spc_pkg::GAIN_W-1:0]          csr_wdata = '0;

   speed_pid_per_channel uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_channel        (req_channel),
      .req_target_speed   (req_target_speed),
      .req_measured_speed (req_measured_speed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive          (rsp_drive),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // predictor state
   logic signed [31:0] gain_p = spc_pkg::GAIN_P_RESET;
   logic signed [31:0] gain_i = spc_pkg::GAIN_I_RESET;
   logic signed [31:0] gain_d = spc_pkg::GAIN_D_RESET;
   logic signed [31:0] integ    [spc_pkg::CHANNELS];
   logic signed [16:0] last_err [spc_pkg::CHANNELS];

   logic signed [31:0] pending_drive [$];
   logic signed [31:0] want;
   int                 mismatches = 0;
   int                 gap_odds = 0;
   int                 hold_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint limit_to(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic signed [31:0] next_drive(logic ch_in, logic signed [15:0] tgt,
                                                     logic signed [15:0] meas);
      int     ch;
      longint err, p, i, d, y;
      ch  = ch_in % spc_pkg::CHANNELS;
      err = longint'(tgt) - longint'(meas);
      p   = sat32(longint'(gain_p) * err);
      i   = limit_to(longint'(integ[ch]) + sat32(longint'(gain_i) * err), INTEG_CAP);
      d   = limit_to(sat32(longint'(gain_d) * (err - longint'(last_err[ch]))), DERIV_CAP);
      y   = limit_to(p + i - d, DRIVE_CAP);
      integ[ch]    = 32'(i);
      last_err[ch] = 17'(err);
      return 32'(y);
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
         2: return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
         3: return $urandom;
         4: return 32'h7FFF_FFFF;
         default: return 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [15:0] corner_speed();
      case ($urandom_range(0, 4))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'hFFFF;
      endcase
   endfunction

   task automatic flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic send_item(logic ch, logic signed [15:0] tgt, logic signed [15:0] meas,
                            logic signed [31:0] drive);
      int gap;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pending_drive.push_back(drive);
      req_valid          <= 1'b1;
      req_channel        <= ch;
      req_target_speed   <= tgt;
      req_measured_speed <= meas;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [spc_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         spc_pkg::REG_GAIN_P: gain_p = data;
         spc_pkg::REG_GAIN_I: gain_i = data;
         spc_pkg::REG_GAIN_D: gain_d = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         hold_left <= $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_drive.size() == 0) begin
            flag_mismatch($sformatf("unexpected item, drive %0d", rsp_drive));
         end else begin
            want = pending_drive.pop_front();
            if (rsp_drive !== want)
               flag_mismatch($sformatf("drive %0d, expected %0d", rsp_drive, want));
         end
      end
   end

   initial begin
      int                 seg, k, r;
      logic               c;
      logic signed [15:0] t, m;
      logic signed [31:0] w;
      step_type           row;
      int                 odds_pick [4];

      odds_pick = '{0, 3, 8, 20};
      for (k = 0; k < spc_pkg::CHANNELS; k++) begin
         integ[k]    = '0;
         last_err[k] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_odds = 4;
      for (r = 0; r < PLAN_LEN; r++) begin
         row = PLAN[r];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_reg(row.idx, row.data);
         end else begin
            w = next_drive(row.ch, row.tgt, row.meas);
            if (row.fixed) w = row.drive;
            send_item(row.ch, row.tgt, row.meas, w);
         end
      end

      for (seg = 0; seg < SEGMENTS; seg++) begin
         wait_idle();
         write_reg(spc_pkg::REG_GAIN_P, pick_gain());
         write_reg(spc_pkg::REG_GAIN_I, pick_gain());
         write_reg(spc_pkg::REG_GAIN_D, pick_gain());
         if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
         gap_odds = (seg >= SEGMENTS - 2) ? 0 : odds_pick[$urandom_range(0, 3)];
         for (k = 0; k < SEG_ITEMS; k++) begin
            c = 1'($urandom);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  t = 16'($urandom);
                  m = t + 16'($urandom_range(0, 80)) - 16'd40;
               end
               5, 6: begin
                  t = 16'($urandom_range(0, 4000)) - 16'd2000;
                  m = 16'($urandom_range(0, 4000)) - 16'd2000;
               end
               7, 8: begin
                  t = 16'($urandom);
                  m = 16'($urandom);
               end
               default: begin
                  t = corner_speed();
                  m = corner_speed();
               end
            endcase
            send_item(c, t, m, next_drive(c, t, m));
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
